/* rtl/pmq_pkg.sv */
package pmq_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_BITS      = 31;
    localparam int SRC_BITS      = 8;
    localparam int ERR_BITS      = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_MOTION_LEVEL = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WARMUP       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_QUAL_MOTION  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_QUAL_CLEAR   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STUCK        = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SOURCE       = 3'd5;

    localparam logic                RST_MOTION_LEVEL = 1'b1;
    localparam logic [CFG_BITS-1:0] RST_WARMUP       = 31'd30000;
    localparam logic [CFG_BITS-1:0] RST_QUAL_MOTION  = 31'd100;
    localparam logic [CFG_BITS-1:0] RST_QUAL_CLEAR   = 31'd1000;
    localparam logic [CFG_BITS-1:0] RST_STUCK        = 31'd600000;
    localparam logic [SRC_BITS-1:0] RST_SOURCE       = 8'd0;

    localparam logic [2:0] PH_WARMING = 3'd0;
    localparam logic [2:0] PH_CLEAR   = 3'd1;
    localparam logic [2:0] PH_MOTION  = 3'd2;
    localparam logic [2:0] PH_STUCK   = 3'd3;
    localparam logic [2:0] PH_FAULT   = 3'd4;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_ARG = 2'd1;
    localparam logic [1:0] ST_CFG = 2'd2;
    localparam logic [1:0] ST_SRC = 2'd3;

    typedef struct packed {
        logic                motion_level;
        logic [CFG_BITS-1:0] warmup_ms;
        logic [CFG_BITS-1:0] qualify_motion_ms;
        logic [CFG_BITS-1:0] qualify_clear_ms;
        logic [CFG_BITS-1:0] stuck_limit_ms;
        logic [SRC_BITS-1:0] expected_source;
    } t_cfg;

    typedef struct packed {
        logic                cmd;
        logic                cfg_ok;
        logic                src_ok;
        logic                level;
        logic [ERR_BITS-1:0] error;
    } t_qctl;

endpackage

/* rtl/pmq_in_if.sv */
interface pmq_in_if #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [TIME_BITS-1:0]         sample_time_ms;
    logic [pmq_pkg::SRC_BITS-1:0] sample_source;
    logic                         sample_level;
    logic [pmq_pkg::ERR_BITS-1:0] sample_error;

    modport source (
        output valid, command, sample_time_ms, sample_source, sample_level, sample_error,
        input  ready
    );
    modport sink (
        input  valid, command, sample_time_ms, sample_source, sample_level, sample_error,
        output ready
    );
endinterface

/* rtl/pmq_out_if.sv */
interface pmq_out_if #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   phase;
    logic                         motion_event;
    logic                         clear_event;
    logic [TIME_BITS-1:0]         stable_for_ms;
    logic [TIME_BITS-1:0]         observed_ms;
    logic                         level_out;
    logic [1:0]                   status_kind;
    logic [pmq_pkg::ERR_BITS-1:0] error_code;

    modport source (
        output valid, phase, motion_event, clear_event, stable_for_ms, observed_ms,
               level_out, status_kind, error_code,
        input  ready
    );
    modport sink (
        input  valid, phase, motion_event, clear_event, stable_for_ms, observed_ms,
               level_out, status_kind, error_code,
        output ready
    );
endinterface

/* rtl/pmq_front.sv */
module pmq_front #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
) (
    pmq_in_if.sink         i_in,
    input  pmq_pkg::t_cfg  i_cfg,
    input  logic           i_q_full,
    output logic           o_push,
    output pmq_pkg::t_qctl o_ctl,
    output logic [TIME_BITS-1:0] o_time
);
    logic cfg_ok;

    assign cfg_ok = (i_cfg.warmup_ms != '0) && (i_cfg.qualify_motion_ms != '0) &&
                    (i_cfg.qualify_clear_ms != '0) &&
                    (i_cfg.stuck_limit_ms >= i_cfg.qualify_motion_ms);

    assign i_in.ready   = !i_q_full;
    assign o_push       = i_in.valid && !i_q_full;
    assign o_ctl.cmd    = i_in.command;
    assign o_ctl.cfg_ok = cfg_ok;
    assign o_ctl.src_ok = (i_in.sample_source == i_cfg.expected_source);
    assign o_ctl.level  = i_in.sample_level;
    assign o_ctl.error  = i_in.sample_error;
    assign o_time       = i_in.sample_time_ms;
endmodule

/* rtl/pmq_queue.sv */
module pmq_queue #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  pmq_pkg::t_qctl       i_ctl,
    input  logic [TIME_BITS-1:0] i_time,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_valid,
    output pmq_pkg::t_qctl       o_ctl,
    output logic [TIME_BITS-1:0] o_time
);
    localparam int DEPTH = pmq_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pmq_pkg::t_qctl       r_ctl  [DEPTH];
    logic [TIME_BITS-1:0] r_time [DEPTH];
    logic [PW-1:0]        r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]        r_count;
    logic [PW-1:0]        n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]        n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_ctl   = r_ctl[r_rd_ptr];
    assign o_time  = r_time[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wr_ptr]  <= i_ctl;
            r_time[r_wr_ptr] <= i_time;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !i_pop |=> $stable(r_count))
        else $error("queue count changed while full and not drained");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("queue drained while empty");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
endmodule

/* rtl/pmq_back.sv */
module pmq_back #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pmq_pkg::t_cfg        i_cfg,
    input  logic                 i_q_valid,
    input  pmq_pkg::t_qctl       i_ctl,
    input  logic [TIME_BITS-1:0] i_time,
    output logic                 o_pop,
    pmq_out_if.source            o_out
);
    localparam int CB = pmq_pkg::CFG_BITS;
    localparam int CW = (TIME_BITS > CB) ? TIME_BITS : CB;
    localparam int EB = pmq_pkg::ERR_BITS;

    logic                 r_has_sample, r_cand_active, r_cand_motion;
    logic [2:0]           r_phase;
    logic                 r_evt_motion, r_evt_clear;
    logic [TIME_BITS-1:0] r_stable, r_obs_time, r_last_time;
    logic [TIME_BITS-1:0] r_warm_start, r_cand_start, r_stable_start;
    logic                 r_obs_level, r_last_level;
    logic [EB-1:0]        r_last_error, r_err;
    logic [1:0]           r_status;

    logic                 n_has_sample, n_cand_active, n_cand_motion;
    logic [2:0]           n_phase;
    logic                 n_evt_motion, n_evt_clear;
    logic [TIME_BITS-1:0] n_stable, n_obs_time, n_last_time;
    logic [TIME_BITS-1:0] n_warm_start, n_cand_start, n_stable_start;
    logic                 n_obs_level, n_last_level;
    logic [EB-1:0]        n_last_error, n_err;
    logic [1:0]           n_status;

    logic                 r_out_valid;
    logic [2:0]           r_out_phase;
    logic                 r_out_evm, r_out_evc, r_out_level;
    logic [TIME_BITS-1:0] r_out_stable, r_out_obs;
    logic [1:0]           r_out_status;
    logic [EB-1:0]        r_out_err;

    logic [TIME_BITS-1:0] t, el_last, el_warm, el_cand, el_stable;
    logic                 motion, cur_motion, new_cand, qualified;
    logic [CB-1:0]        need;

    assign t       = i_time;
    assign o_pop   = i_q_valid && (!r_out_valid || o_out.ready);
    assign el_last = t - r_last_time;

    always_comb begin
        n_has_sample   = r_has_sample;
        n_cand_active  = r_cand_active;
        n_cand_motion  = r_cand_motion;
        n_phase        = r_phase;
        n_evt_motion   = r_evt_motion;
        n_evt_clear    = r_evt_clear;
        n_stable       = r_stable;
        n_obs_time     = r_obs_time;
        n_obs_level    = r_obs_level;
        n_last_time    = r_last_time;
        n_last_level   = r_last_level;
        n_last_error   = r_last_error;
        n_warm_start   = r_warm_start;
        n_cand_start   = r_cand_start;
        n_stable_start = r_stable_start;
        n_status       = r_status;
        n_err          = r_err;
        el_warm        = '0;
        el_cand        = '0;
        el_stable      = '0;
        motion         = 1'b0;
        cur_motion     = 1'b0;
        new_cand       = 1'b0;
        qualified      = 1'b0;
        need           = '0;

        if (i_ctl.cmd) begin
            n_has_sample   = 1'b0;
            n_cand_active  = 1'b0;
            n_cand_motion  = 1'b0;
            n_phase        = pmq_pkg::PH_WARMING;
            n_evt_motion   = 1'b0;
            n_evt_clear    = 1'b0;
            n_stable       = '0;
            n_obs_time     = '0;
            n_obs_level    = 1'b0;
            n_last_time    = '0;
            n_last_level   = 1'b0;
            n_last_error   = '0;
            n_warm_start   = '0;
            n_cand_start   = '0;
            n_stable_start = '0;
            n_status       = pmq_pkg::ST_OK;
            n_err          = '0;
        end else if (i_ctl.cfg_ok && r_phase != pmq_pkg::PH_FAULT) begin
            priority if (r_has_sample && t == r_last_time) begin
                if (!(i_ctl.src_ok && i_ctl.level == r_last_level &&
                      i_ctl.error == r_last_error)) begin
                    n_phase      = pmq_pkg::PH_FAULT;
                    n_evt_motion = 1'b0;
                    n_evt_clear  = 1'b0;
                    n_status     = pmq_pkg::ST_ARG;
                    n_err        = '0;
                end
            end else if (!i_ctl.src_ok || (r_has_sample && el_last[TIME_BITS-1])) begin
                n_phase      = pmq_pkg::PH_FAULT;
                n_evt_motion = 1'b0;
                n_evt_clear  = 1'b0;
                n_status     = pmq_pkg::ST_ARG;
                n_err        = '0;
            end else if (i_ctl.error != '0) begin
                n_obs_time   = t;
                n_obs_level  = i_ctl.level;
                n_phase      = pmq_pkg::PH_FAULT;
                n_evt_motion = 1'b0;
                n_evt_clear  = 1'b0;
                n_stable     = '0;
                n_status     = pmq_pkg::ST_SRC;
                n_err        = i_ctl.error;
                n_last_time  = t;
                n_last_level = i_ctl.level;
                n_last_error = i_ctl.error;
                n_has_sample = 1'b1;
            end else begin
                n_obs_time   = t;
                n_obs_level  = i_ctl.level;
                n_evt_motion = 1'b0;
                n_evt_clear  = 1'b0;
                n_status     = pmq_pkg::ST_OK;
                n_err        = '0;
                n_last_time  = t;
                n_last_level = i_ctl.level;
                n_last_error = i_ctl.error;
                n_has_sample = 1'b1;
                if (!r_has_sample) begin
                    n_warm_start   = t;
                    n_stable_start = t;
                end
                el_warm = r_has_sample ? (t - r_warm_start) : '0;
                if (r_phase == pmq_pkg::PH_WARMING &&
                    CW'(el_warm) < CW'(i_cfg.warmup_ms)) begin
                    n_stable = el_warm;
                end else begin
                    motion     = (i_ctl.level == i_cfg.motion_level);
                    cur_motion = (r_phase == pmq_pkg::PH_MOTION) ||
                                 (r_phase == pmq_pkg::PH_STUCK);
                    if (r_phase != pmq_pkg::PH_WARMING && motion == cur_motion) begin
                        n_cand_active = 1'b0;
                    end else if (!r_cand_active || r_cand_motion != motion) begin
                        n_cand_active = 1'b1;
                        n_cand_motion = motion;
                        n_cand_start  = t;
                        new_cand      = 1'b1;
                    end
                    el_cand = new_cand ? '0 : (t - r_cand_start);
                    need    = n_cand_motion ? i_cfg.qualify_motion_ms
                                            : i_cfg.qualify_clear_ms;
                    if (n_cand_active && CW'(el_cand) >= CW'(need)) begin
                        qualified      = 1'b1;
                        n_phase        = n_cand_motion ? pmq_pkg::PH_MOTION
                                                       : pmq_pkg::PH_CLEAR;
                        n_evt_motion   = n_cand_motion;
                        n_evt_clear    = !n_cand_motion;
                        n_stable_start = t;
                        n_cand_active  = 1'b0;
                    end
                    el_stable = qualified ? '0 : (t - n_stable_start);
                    n_stable  = el_stable;
                    if (n_phase == pmq_pkg::PH_MOTION &&
                        CW'(el_stable) >= CW'(i_cfg.stuck_limit_ms)) begin
                        n_phase = pmq_pkg::PH_STUCK;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_sample   <= 1'b0;
            r_cand_active  <= 1'b0;
            r_cand_motion  <= 1'b0;
            r_phase        <= pmq_pkg::PH_WARMING;
            r_evt_motion   <= 1'b0;
            r_evt_clear    <= 1'b0;
            r_stable       <= '0;
            r_obs_time     <= '0;
            r_obs_level    <= 1'b0;
            r_last_time    <= '0;
            r_last_level   <= 1'b0;
            r_last_error   <= '0;
            r_warm_start   <= '0;
            r_cand_start   <= '0;
            r_stable_start <= '0;
            r_status       <= pmq_pkg::ST_OK;
            r_err          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_has_sample   <= n_has_sample;
                r_cand_active  <= n_cand_active;
                r_cand_motion  <= n_cand_motion;
                r_phase        <= n_phase;
                r_evt_motion   <= n_evt_motion;
                r_evt_clear    <= n_evt_clear;
                r_stable       <= n_stable;
                r_obs_time     <= n_obs_time;
                r_obs_level    <= n_obs_level;
                r_last_time    <= n_last_time;
                r_last_level   <= n_last_level;
                r_last_error   <= n_last_error;
                r_warm_start   <= n_warm_start;
                r_cand_start   <= n_cand_start;
                r_stable_start <= n_stable_start;
                r_status       <= n_status;
                r_err          <= n_err;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            if (i_ctl.cfg_ok) begin
                r_out_phase  <= n_phase;
                r_out_evm    <= n_evt_motion;
                r_out_evc    <= n_evt_clear;
                r_out_stable <= n_stable;
                r_out_obs    <= n_obs_time;
                r_out_level  <= n_obs_level;
                r_out_status <= n_status;
                r_out_err    <= (n_status == pmq_pkg::ST_SRC) ? n_err : '0;
            end else begin
                r_out_phase  <= pmq_pkg::PH_WARMING;
                r_out_evm    <= 1'b0;
                r_out_evc    <= 1'b0;
                r_out_stable <= '0;
                r_out_obs    <= '0;
                r_out_level  <= 1'b0;
                r_out_status <= pmq_pkg::ST_CFG;
                r_out_err    <= '0;
            end
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.phase         = r_out_phase;
    assign o_out.motion_event  = r_out_evm;
    assign o_out.clear_event   = r_out_evc;
    assign o_out.stable_for_ms = r_out_stable;
    assign o_out.observed_ms   = r_out_obs;
    assign o_out.level_out     = r_out_level;
    assign o_out.status_kind   = r_out_status;
    assign o_out.error_code    = r_out_err;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_evt_motion && r_evt_clear))
        else $error("both qualification events raised at once");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_evt_motion |-> (r_phase == pmq_pkg::PH_MOTION || r_phase == pmq_pkg::PH_STUCK))
        else $error("motion event outside a motion phase");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && i_ctl.cmd |=> (r_phase == pmq_pkg::PH_WARMING && !r_has_sample))
        else $error("reset command did not restart warm-up");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && !i_ctl.cmd && r_phase == pmq_pkg::PH_FAULT |=> r_phase == pmq_pkg::PH_FAULT)
        else $error("fault released without a reset command");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err != '0 |-> r_out_status == pmq_pkg::ST_SRC)
        else $error("error code reported without a source error");
endmodule

/* rtl/pir_motion_qualifier_core.sv */
// An accepted item is written into the queue; the back end pops it and registers its result.
// Throughput: one item per cycle unless the output stalls; each pop updates the state.
// A two-entry queue decouples input acceptance from output stalls.
// Reset (synchronous, active low) restarts warm-up, clears the queue and the result
// valid flag, and loads every configuration register with its default.
module pir_motion_qualifier_core #(
    parameter int TIME_BITS = pmq_pkg::TIME_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pmq_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [pmq_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    pmq_in_if.sink                           i_in,
    pmq_out_if.source                        o_out
);
    pmq_pkg::t_cfg        r_cfg;
    logic                 push, pop, q_full, q_valid;
    pmq_pkg::t_qctl       f_ctl, q_ctl;
    logic [TIME_BITS-1:0] f_time, q_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_level      <= pmq_pkg::RST_MOTION_LEVEL;
            r_cfg.warmup_ms         <= pmq_pkg::RST_WARMUP;
            r_cfg.qualify_motion_ms <= pmq_pkg::RST_QUAL_MOTION;
            r_cfg.qualify_clear_ms  <= pmq_pkg::RST_QUAL_CLEAR;
            r_cfg.stuck_limit_ms    <= pmq_pkg::RST_STUCK;
            r_cfg.expected_source   <= pmq_pkg::RST_SOURCE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pmq_pkg::CFG_IDX_MOTION_LEVEL: r_cfg.motion_level      <= i_cfg_wdata[0];
                pmq_pkg::CFG_IDX_WARMUP:       r_cfg.warmup_ms         <= i_cfg_wdata;
                pmq_pkg::CFG_IDX_QUAL_MOTION:  r_cfg.qualify_motion_ms <= i_cfg_wdata;
                pmq_pkg::CFG_IDX_QUAL_CLEAR:   r_cfg.qualify_clear_ms  <= i_cfg_wdata;
                pmq_pkg::CFG_IDX_STUCK:        r_cfg.stuck_limit_ms    <= i_cfg_wdata;
                pmq_pkg::CFG_IDX_SOURCE:
                    r_cfg.expected_source <= i_cfg_wdata[pmq_pkg::SRC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    pmq_front #(.TIME_BITS(TIME_BITS)) u_front (
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_ctl    (f_ctl),
        .o_time   (f_time)
    );

    pmq_queue #(.TIME_BITS(TIME_BITS)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ctl   (f_ctl),
        .i_time  (f_time),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_ctl   (q_ctl),
        .o_time  (q_time)
    );

    pmq_back #(.TIME_BITS(TIME_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_ctl     (q_ctl),
        .i_time    (q_time),
        .o_pop     (pop),
        .o_out     (o_out)
    );
endmodule
